@@ hdl/ctc_pkg.sv @@
// Shared types and constants for the climate threshold controller.
package ctc_pkg;

  localparam int TEMP_W       = 16;
  localparam int ACTION_W     = 2;
  localparam int NUM_REGS     = 7;
  localparam int REG_IDX_W    = 3;
  localparam int BUZZ_CNT_W   = 8;

  localparam int HOT_BUZZ_PERIOD_DEF  = 250;
  localparam int COLD_BUZZ_PERIOD_DEF = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MEASURE    = 2'd0,
    ACT_WATER_TICK = 2'd1,
    ACT_BUZZ_TICK  = 2'd2
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FAN_ONE    = 3'd0,
    REG_FAN_TWO    = 3'd1,
    REG_WATER      = 3'd2,
    REG_HEATER_ONE = 3'd3,
    REG_HEATER_TWO = 3'd4,
    REG_QUIET      = 3'd5,
    REG_PULSE      = 3'd6
  } reg_idx_t;

  localparam logic [TEMP_W-1:0] FAN_ONE_RST    = 16'd4500;
  localparam logic [TEMP_W-1:0] FAN_TWO_RST    = 16'd6000;
  localparam logic [TEMP_W-1:0] WATER_RST      = 16'd3000;
  localparam logic [TEMP_W-1:0] HEATER_ONE_RST = 16'd1500;
  localparam logic [TEMP_W-1:0] HEATER_TWO_RST = 16'd1000;
  localparam logic [TEMP_W-1:0] QUIET_RST      = 16'd1600;
  localparam logic [TEMP_W-1:0] PULSE_RST      = 16'd1875;

  typedef struct packed {
    logic [TEMP_W-1:0] fan_one_level;
    logic [TEMP_W-1:0] fan_two_level;
    logic [TEMP_W-1:0] water_level;
    logic [TEMP_W-1:0] heater_one_level;
    logic [TEMP_W-1:0] heater_two_level;
    logic [TEMP_W-1:0] quiet_upper_level;
    logic [TEMP_W-1:0] water_pulse_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic fan_one;
    logic fan_two;
    logic heater_one;
    logic heater_two;
    logic water_valve;
    logic buzzer_level;
  } result_t;

endpackage

@@ hdl/ctc_if.sv @@
// Channel interfaces: measurement/tick items, drive results, register writes.
interface ctc_item_if;
  logic                               valid;
  logic                               ready;
  logic [ctc_pkg::ACTION_W-1:0]       action;
  logic [ctc_pkg::TEMP_W-1:0]         temperature;
  modport source (output valid, action, temperature, input ready);
  modport sink   (input valid, action, temperature, output ready);
endinterface

interface ctc_result_if;
  logic valid;
  logic ready;
  logic fan_one;
  logic fan_two;
  logic heater_one;
  logic heater_two;
  logic water_valve;
  logic buzzer_level;
  modport source (output valid, fan_one, fan_two, heater_one, heater_two, water_valve,
                  buzzer_level, input ready);
  modport sink   (input valid, fan_one, fan_two, heater_one, heater_two, water_valve,
                  buzzer_level, output ready);
endinterface

interface ctc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ctc_pkg::REG_IDX_W-1:0]      index;
  logic [ctc_pkg::TEMP_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/climate_threshold_controller_top.sv @@
// Climate threshold controller: fans, heaters, alarm buzzer and water valve.
//
//  channel  | dir | payload                                        | transfer
//  item     | in  | action, temperature                            | valid & ready
//  result   | out | fan_one, fan_two, heater_one, heater_two,      | valid & ready
//           |     | water_valve, buzzer_level                      |
//  cfg      | in  | index, data                                    | valid & ready
//
//  One item per cycle while item.ready is high: the control state updates at the item
//  transfer and the drive outputs land in the result register on the same edge.
//  item.ready is high while the result register is empty or being drained.
//  cfg.ready is always high. rst is synchronous and restores the register defaults.
module climate_threshold_controller_top #(
  parameter int HOT_BUZZ_PERIOD  = ctc_pkg::HOT_BUZZ_PERIOD_DEF,
  parameter int COLD_BUZZ_PERIOD = ctc_pkg::COLD_BUZZ_PERIOD_DEF
) (
  input logic           clk,
  input logic           rst,
  ctc_item_if.sink      item,
  ctc_result_if.source  result,
  ctc_cfg_if.sink       cfg
);

  localparam int TW = ctc_pkg::TEMP_W;
  localparam int BW = ctc_pkg::BUZZ_CNT_W;
  localparam logic [BW:0] HOT_PERIOD  = (BW+1)'(HOT_BUZZ_PERIOD);
  localparam logic [BW:0] COLD_PERIOD = (BW+1)'(COLD_BUZZ_PERIOD);

  ctc_pkg::cfg_regs_t regs;

  logic          primed, primed_next;
  logic [TW-1:0] cur_temp, cur_temp_next;
  logic [1:0]    fan_states, fan_states_next;
  logic [1:0]    heater_states, heater_states_next;
  logic          water_active, water_active_next;
  logic [TW-1:0] valve_ticks, valve_ticks_next;
  logic          alarm_enabled, alarm_enabled_next;
  logic          alarm_is_cold, alarm_is_cold_next;
  logic          buzz_pin, buzz_pin_next;
  logic [BW-1:0] buzz_count, buzz_count_next;
  logic          buzz_running, buzz_running_next;

  ctc_pkg::result_t res_q;
  logic             res_valid;

  logic          item_xfer;
  logic [TW-1:0] t;
  logic [TW-1:0] water_inc;
  logic [BW:0]   buzz_inc;
  logic [BW:0]   period;

  assign item.ready = !res_valid || result.ready;
  assign item_xfer  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;
  assign t          = item.temperature;
  assign water_inc  = valve_ticks + TW'(1);
  assign buzz_inc   = {1'b0, buzz_count} + (BW+1)'(1);
  assign period     = alarm_is_cold ? COLD_PERIOD : HOT_PERIOD;

  always_comb begin
    primed_next        = primed;
    cur_temp_next      = cur_temp;
    fan_states_next    = fan_states;
    heater_states_next = heater_states;
    water_active_next  = water_active;
    valve_ticks_next   = valve_ticks;
    alarm_enabled_next = alarm_enabled;
    alarm_is_cold_next = alarm_is_cold;
    buzz_pin_next      = buzz_pin;
    buzz_count_next    = buzz_count;
    buzz_running_next  = buzz_running;
    unique case (ctc_pkg::action_t'(item.action))
      ctc_pkg::ACT_MEASURE: begin
        cur_temp_next = t;
        if (!primed) begin
          primed_next = 1'b1;
        end else begin
          if (t >= regs.fan_one_level) begin
            fan_states_next[0] = 1'b1;
            if (t >= regs.fan_two_level) begin
              fan_states_next[1] = 1'b1;
              alarm_is_cold_next = 1'b0;
              alarm_enabled_next = 1'b1;
              buzz_running_next  = 1'b1;
            end else begin
              fan_states_next[1] = 1'b0;
              alarm_enabled_next = 1'b0;
            end
          end else begin
            // hold fan two
            fan_states_next[0] = 1'b0;
          end
          if (!water_active &&
              ((cur_temp < regs.water_level && t >= regs.water_level) ||
               (cur_temp > regs.water_level && t <= regs.water_level))) begin
            water_active_next = 1'b1;
            valve_ticks_next  = '0;
          end
          heater_states_next[0] = (t <= regs.heater_one_level);
          if (t <= regs.heater_two_level) begin
            heater_states_next[1] = 1'b1;
            alarm_is_cold_next    = 1'b1;
            alarm_enabled_next    = 1'b1;
            buzz_running_next     = 1'b1;
          end else begin
            heater_states_next[1] = 1'b0;
          end
          if (t > regs.heater_two_level && t < regs.quiet_upper_level) begin
            alarm_enabled_next = 1'b0;
          end
        end
      end
      ctc_pkg::ACT_WATER_TICK: begin
        if (water_active) begin
          if (water_inc == regs.water_pulse_ticks) begin
            water_active_next = 1'b0;
            valve_ticks_next  = '0;
          end else begin
            valve_ticks_next = water_inc;
          end
        end
      end
      ctc_pkg::ACT_BUZZ_TICK: begin
        if (buzz_running) begin
          // a zero period wraps on every tick, same as a period of one
          if (buzz_inc >= period) begin
            buzz_count_next = '0;
            if (alarm_enabled) begin
              buzz_pin_next = !buzz_pin;
            end else begin
              buzz_pin_next     = 1'b0;
              buzz_running_next = 1'b0;
            end
          end else begin
            buzz_count_next = buzz_inc[BW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fan_one_level     <= ctc_pkg::FAN_ONE_RST;
      regs.fan_two_level     <= ctc_pkg::FAN_TWO_RST;
      regs.water_level       <= ctc_pkg::WATER_RST;
      regs.heater_one_level  <= ctc_pkg::HEATER_ONE_RST;
      regs.heater_two_level  <= ctc_pkg::HEATER_TWO_RST;
      regs.quiet_upper_level <= ctc_pkg::QUIET_RST;
      regs.water_pulse_ticks <= ctc_pkg::PULSE_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (ctc_pkg::reg_idx_t'(cfg.index))
        ctc_pkg::REG_FAN_ONE:    regs.fan_one_level     <= cfg.data;
        ctc_pkg::REG_FAN_TWO:    regs.fan_two_level     <= cfg.data;
        ctc_pkg::REG_WATER:      regs.water_level       <= cfg.data;
        ctc_pkg::REG_HEATER_ONE: regs.heater_one_level  <= cfg.data;
        ctc_pkg::REG_HEATER_TWO: regs.heater_two_level  <= cfg.data;
        ctc_pkg::REG_QUIET:      regs.quiet_upper_level <= cfg.data;
        ctc_pkg::REG_PULSE:      regs.water_pulse_ticks <= cfg.data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed        <= 1'b0;
      cur_temp      <= '0;
      fan_states    <= '0;
      heater_states <= '0;
      water_active  <= 1'b0;
      valve_ticks   <= '0;
      alarm_enabled <= 1'b0;
      alarm_is_cold <= 1'b0;
      buzz_pin      <= 1'b0;
      buzz_count    <= '0;
      buzz_running  <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (item_xfer) begin
        primed        <= primed_next;
        cur_temp      <= cur_temp_next;
        fan_states    <= fan_states_next;
        heater_states <= heater_states_next;
        water_active  <= water_active_next;
        valve_ticks   <= valve_ticks_next;
        alarm_enabled <= alarm_enabled_next;
        alarm_is_cold <= alarm_is_cold_next;
        buzz_pin      <= buzz_pin_next;
        buzz_count    <= buzz_count_next;
        buzz_running  <= buzz_running_next;
        res_valid     <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      res_q.fan_one      <= fan_states_next[0];
      res_q.fan_two      <= fan_states_next[1];
      res_q.heater_one   <= heater_states_next[0];
      res_q.heater_two   <= heater_states_next[1];
      res_q.water_valve  <= water_active_next;
      res_q.buzzer_level <= buzz_pin_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.fan_one      = res_q.fan_one;
  assign result.fan_two      = res_q.fan_two;
  assign result.heater_one   = res_q.heater_one;
  assign result.heater_two   = res_q.heater_two;
  assign result.water_valve  = res_q.water_valve;
  assign result.buzzer_level = res_q.buzzer_level;

endmodule
